/* src/itm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itm_pkg: shared types and codes for the interval match table
// Operation codes, result status codes and the compare-unit flag bundle.
// ----------------------------------------------------------------------------
package itm_pkg;

    localparam int TALLY_BITS = 64;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TEST = 1'b1
    } itm_op_t;

    typedef enum logic [1:0] {
        ST_MERGE  = 2'd0,
        ST_APPEND = 2'd1,
        ST_DROP   = 2'd2,
        ST_QUERY  = 2'd3
    } itm_status_t;

    // flags from the compare unit for one stored entry
    typedef struct packed {
        logic cov_a;   // entry contains first value
        logic cov_b;   // entry contains second value
    } itm_cmp_t;

endpackage

/* src/itm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itm_if: request and response channels of the interval match table
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface itm_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] first_value;
    logic [63:0] second_value;

    modport source (output valid, output op, output first_value, output second_value,
                    input ready);
    modport sink   (input valid, input op, input first_value, input second_value,
                    output ready);
endinterface

interface itm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        hit;
    logic [63:0] hit_total;

    modport source (output valid, output status, output hit, output hit_total,
                    input ready);
    modport sink   (input valid, input status, input hit, input hit_total,
                    output ready);
endinterface

/* src/interval_table_merge_and_match_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_merge_and_match_top: interval table with merge and match
// Keeps up to ENTRIES inclusive intervals; adds/merges intervals and tests
// values for membership, one request transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request channel (sink). op=OP_ADD adds [first_value, second_value],
//          op=OP_TEST tests first_value. Values are cut to VALUE_BITS bits.
//   rsp  - response channel (source). One response per request: status,
//          hit flag and the running saturating hit total.
//   Scan: a request scans the n stored entries in order, one entry per
//   cycle through the single read port of the store and the shared compare
//   unit; it stops at the first match. req.ready is low for the whole scan
//   and until the result moves into the output register, so a new request
//   is taken only once the last result has moved there.
//   Reset: the table is empty and the hit total is zero; the store itself is
//   not cleared, only entries below the fill count are ever read.
//   Stall: the response sits in an output register. A finished result waits
//   there for rsp.ready; a following request is accepted and scanned
//   meanwhile, and its result is held until the output register frees.
// ----------------------------------------------------------------------------
module interval_table_merge_and_match_top
    import itm_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 64
)(
    input  logic       clk,
    input  logic       rst_n,
    itm_req_if.sink    req,
    itm_rsp_if.source  rsp
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t                 state_reg;
    itm_op_t                op_reg;
    logic [VALUE_BITS-1:0]  a_reg;
    logic [VALUE_BITS-1:0]  b_reg;
    logic [CW-1:0]          cnt_reg;      // entries in use
    logic [CW-1:0]          rd_idx_reg;   // next entry to read
    logic [AW-1:0]          cmp_idx_reg;  // entry whose data is on the read port
    logic                   cmp_vld_reg;  // read data valid this cycle
    itm_status_t            res_status_reg;
    logic                   res_hit_reg;
    logic [TALLY_BITS-1:0]  tally_reg;
    logic                   rsp_vld_reg;
    itm_status_t            rsp_status_reg;
    logic                   rsp_hit_reg;
    logic [TALLY_BITS-1:0]  rsp_total_reg;

    logic                   req_fire;
    logic                   rsp_free;
    logic                   more;
    logic                   match;
    logic                   rd_en;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_BITS-1:0]  wr_low;
    logic [VALUE_BITS-1:0]  wr_high;
    logic [VALUE_BITS-1:0]  rd_low;
    logic [VALUE_BITS-1:0]  rd_high;
    logic [VALUE_BITS-1:0]  new_low;
    logic [VALUE_BITS-1:0]  new_high;
    itm_cmp_t               flags;
    logic                   table_full;
    logic [TALLY_BITS-1:0]  tally_next;

    itm_store #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_low  (wr_low),
        .wr_high (wr_high),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_low  (rd_low),
        .rd_high (rd_high)
    );

    itm_compare #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .low      (rd_low),
        .high     (rd_high),
        .a        (a_reg),
        .b        (b_reg),
        .flags    (flags),
        .new_low  (new_low),
        .new_high (new_high)
    );

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign rsp_free   = !rsp_vld_reg || rsp.ready;
    assign more       = (rd_idx_reg != cnt_reg);
    assign table_full = (cnt_reg == CW'(ENTRIES));

    // a query only cares about the first value; an add matches on either end
    assign match = cmp_vld_reg &&
                   (flags.cov_a || (op_reg == OP_ADD && flags.cov_b));

    assign rd_en = (state_reg == S_SCAN) && !match && more;

    // at most one write per add: merge into the matched entry, or append at the end
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmp_idx_reg;
        wr_low  = new_low;
        wr_high = new_high;
        if (state_reg == S_SCAN && op_reg == OP_ADD)
        begin
            if (match)
            begin
                wr_en = 1'b1;
            end
            else if (!more && !table_full)
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[AW-1:0];
                wr_low  = a_reg;
                wr_high = b_reg;
            end
        end
    end

    assign tally_next = (res_hit_reg && tally_reg != '1) ? tally_reg + 1'b1 : tally_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_ADD;
            a_reg          <= '0;
            b_reg          <= '0;
            cnt_reg        <= '0;
            rd_idx_reg     <= '0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            tally_reg      <= '0;
            rsp_vld_reg    <= 1'b0;
            rsp_status_reg <= ST_QUERY;
            rsp_hit_reg    <= 1'b0;
            rsp_total_reg  <= '0;
            res_status_reg <= ST_QUERY;
            res_hit_reg    <= 1'b0;
        end
        else
        begin
            // in S_FIN the output register is either reloaded or still held
            if (rsp.ready && state_reg != S_FIN)
            begin
                rsp_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg      <= itm_op_t'(req.op);
                        a_reg       <= req.first_value[VALUE_BITS-1:0];
                        b_reg       <= req.second_value[VALUE_BITS-1:0];
                        rd_idx_reg  <= '0;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (match)
                    begin
                        cmp_vld_reg    <= 1'b0;
                        res_status_reg <= (op_reg == OP_TEST) ? ST_QUERY : ST_MERGE;
                        res_hit_reg    <= (op_reg == OP_TEST);
                        state_reg      <= S_FIN;
                    end
                    else if (more)
                    begin
                        cmp_idx_reg <= rd_idx_reg[AW-1:0];
                        cmp_vld_reg <= 1'b1;
                        rd_idx_reg  <= rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b0;
                        res_hit_reg <= 1'b0;
                        state_reg   <= S_FIN;
                        if (op_reg == OP_TEST)
                        begin
                            res_status_reg <= ST_QUERY;
                        end
                        else if (table_full)
                        begin
                            res_status_reg <= ST_DROP;
                        end
                        else
                        begin
                            res_status_reg <= ST_APPEND;
                            cnt_reg        <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_FIN:
                begin
                    if (rsp_free)
                    begin
                        tally_reg      <= tally_next;
                        rsp_vld_reg    <= 1'b1;
                        rsp_status_reg <= res_status_reg;
                        rsp_hit_reg    <= res_hit_reg;
                        rsp_total_reg  <= tally_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid     = rsp_vld_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.hit       = rsp_hit_reg;
    assign rsp.hit_total = rsp_total_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("fill count beyond table depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> rd_idx_reg <= cnt_reg)
        else $error("scan index past fill count");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && res_status_reg == ST_DROP) |-> table_full)
        else $error("drop reported with room in table");

    a_tally_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> tally_reg >= $past(tally_reg))
        else $error("hit total decreased");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("store read and written in one cycle");

endmodule

/* src/itm_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itm_store: interval storage
// Low and high bound arrays, one write port, one registered read port.
// ----------------------------------------------------------------------------
module itm_store
    import itm_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 64,
    localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [VALUE_BITS-1:0] wr_low,
    input  logic [VALUE_BITS-1:0] wr_high,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [VALUE_BITS-1:0] rd_low,
    output logic [VALUE_BITS-1:0] rd_high
);

    logic [VALUE_BITS-1:0] low_mem  [ENTRIES];
    logic [VALUE_BITS-1:0] high_mem [ENTRIES];
    logic [VALUE_BITS-1:0] rd_low_reg;
    logic [VALUE_BITS-1:0] rd_high_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            low_mem[wr_addr]  <= wr_low;
            high_mem[wr_addr] <= wr_high;
        end
        if (rd_en)
        begin
            rd_low_reg  <= low_mem[rd_addr];
            rd_high_reg <= high_mem[rd_addr];
        end
    end

    assign rd_low  = rd_low_reg;
    assign rd_high = rd_high_reg;

endmodule

/* src/itm_compare.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itm_compare: shared compare unit
// Tests both values against one entry and forms the widened bounds.
// ----------------------------------------------------------------------------
module itm_compare
    import itm_pkg::*;
#(
    parameter int VALUE_BITS = 64
)(
    input  logic [VALUE_BITS-1:0] low,
    input  logic [VALUE_BITS-1:0] high,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    output itm_cmp_t              flags,
    output logic [VALUE_BITS-1:0] new_low,
    output logic [VALUE_BITS-1:0] new_high
);

    logic a_ge_low;
    logic a_le_high;
    logic b_ge_low;
    logic b_le_high;

    assign a_ge_low  = (a >= low);
    assign a_le_high = (a <= high);
    assign b_ge_low  = (b >= low);
    assign b_le_high = (b <= high);

    assign flags.cov_a = a_ge_low && a_le_high;
    assign flags.cov_b = b_ge_low && b_le_high;

    // start inside: stretch toward end; otherwise stretch toward start
    always_comb
    begin
        if (flags.cov_a)
        begin
            new_low  = b_ge_low  ? low  : b;
            new_high = b_le_high ? high : b;
        end
        else
        begin
            new_low  = a_ge_low  ? low  : a;
            new_high = a_le_high ? high : a;
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the interval match table
// Runs a short directed table, then random add/test transactions against a
// bench-side copy of the interval table; every response is compared field by
// field with the oldest predicted response, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import itm_pkg::*;

    localparam int          ENTRIES    = 64;
    localparam int          VALUE_BITS = 64;
    localparam logic [63:0] VAL_MASK   = (VALUE_BITS >= 64) ? '1 :
                                         ((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [63:0] VMAX       = '1;
    localparam int          RAND_ITEMS = 400;
    localparam int          LONG_HOLD  = 400;       // cycles the receiver stays off
    localparam int          QUIET_TAIL = 80;        // last items run with no idling

    // one response as the block reports it
    typedef struct packed {
        itm_status_t status;
        logic        hit;
        logic [63:0] hit_total;
    } match_rsp_t;

    // one row of the directed table; typed rows carry their own answer
    typedef struct {
        itm_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
        bit          typed;
        match_rsp_t  want;
    } stim_row_t;

    localparam match_rsp_t UNTYPED = '{ST_MERGE, 1'b0, 64'd0};

    logic clk;
    logic rst_n;

    itm_req_if req_ch ();
    itm_rsp_if rsp_ch ();

    interval_table_merge_and_match_top #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // bench copy of the table
    logic [63:0] tbl_lo [ENTRIES];
    logic [63:0] tbl_hi [ENTRIES];
    int          tbl_count;
    logic [63:0] hits_seen;

    match_rsp_t  pending_rsp [$];       // responses owed by the block, oldest first
    int          mismatch_count;
    bit          idle_on;               // random gaps on both sides
    bit          long_hold_req;         // asks the receiver for one long hold-off

    // Directed table: empty-table queries, start-side and end-side merges, the
    // scan-order rule (an earlier entry holding the end beats a later one
    // holding the start), a reversed interval, and the value extremes.
    stim_row_t dir_rows [] = '{
        '{OP_TEST, 64'd0,  64'd0,  1'b1, '{ST_QUERY,  1'b0, 64'd0}},
        '{OP_TEST, VMAX,   VMAX,   1'b1, '{ST_QUERY,  1'b0, 64'd0}},
        '{OP_ADD,  64'd10, 64'd20, 1'b1, '{ST_APPEND, 1'b0, 64'd0}},
        '{OP_TEST, 64'd10, 64'd0,  1'b1, '{ST_QUERY,  1'b1, 64'd1}},
        '{OP_TEST, 64'd20, VMAX,   1'b1, '{ST_QUERY,  1'b1, 64'd2}},
        '{OP_TEST, 64'd21, 64'd0,  1'b1, '{ST_QUERY,  1'b0, 64'd2}},
        '{OP_TEST, 64'd9,  64'd0,  1'b1, '{ST_QUERY,  1'b0, 64'd2}},
        '{OP_ADD,  64'd15, 64'd30, 1'b0, UNTYPED},
        '{OP_ADD,  64'd5,  64'd12, 1'b0, UNTYPED},
        '{OP_TEST, 64'd30, 64'd0,  1'b0, UNTYPED},
        '{OP_TEST, 64'd5,  64'd0,  1'b0, UNTYPED},
        '{OP_ADD,  64'd100, 64'd50, 1'b0, UNTYPED},
        '{OP_TEST, 64'd75, 64'd0,  1'b0, UNTYPED},
        '{OP_TEST, 64'd100, 64'd0, 1'b0, UNTYPED},
        '{OP_ADD,  64'd0,  64'd0,  1'b0, UNTYPED},
        '{OP_ADD,  VMAX,   VMAX,   1'b0, UNTYPED},
        '{OP_TEST, 64'd0,  VMAX,   1'b0, UNTYPED},
        '{OP_TEST, VMAX,   64'd0,  1'b0, UNTYPED},
        '{OP_ADD,  64'd40, 64'd45, 1'b0, UNTYPED},
        '{OP_ADD,  64'd35, 64'd42, 1'b0, UNTYPED},
        '{OP_ADD,  64'd28, 64'd38, 1'b0, UNTYPED},
        '{OP_ADD,  64'd41, 64'd8,  1'b0, UNTYPED},
        '{OP_ADD,  VMAX - 64'd5, VMAX - 64'd1, 1'b0, UNTYPED},
        '{OP_ADD,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, UNTYPED},
        '{OP_TEST, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, UNTYPED}
    };

    // 50 MHz clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Table prediction
    // ------------------------------------------------------------------------
    function automatic bit in_entry(int idx, logic [63:0] v);
        return (tbl_lo[idx] <= v) && (v <= tbl_hi[idx]);
    endfunction

    function automatic void widen_entry(int idx, logic [63:0] v);
        if (v < tbl_lo[idx])
            tbl_lo[idx] = v;
        if (v > tbl_hi[idx])
            tbl_hi[idx] = v;
    endfunction

    // Applies one transaction to the bench table and returns the response
    // the block owes for it.
    function automatic match_rsp_t predict_txn(itm_op_t op, logic [63:0] a_in,
                                               logic [63:0] b_in);
        logic [63:0] a;
        logic [63:0] b;
        match_rsp_t  r;
        bit          found;
        a     = a_in & VAL_MASK;
        b     = b_in & VAL_MASK;
        found = 1'b0;
        r.hit = 1'b0;
        if (op == OP_ADD) begin
            // per entry, the start is checked before the end
            for (int i = 0; i < tbl_count && !found; i++) begin
                if (in_entry(i, a)) begin
                    widen_entry(i, b);
                    found = 1'b1;
                end
                else if (in_entry(i, b)) begin
                    widen_entry(i, a);
                    found = 1'b1;
                end
            end
            if (found)
                r.status = ST_MERGE;
            else if (tbl_count < ENTRIES) begin
                // stored as given, even when reversed
                tbl_lo[tbl_count] = a;
                tbl_hi[tbl_count] = b;
                tbl_count++;
                r.status = ST_APPEND;
            end
            else
                r.status = ST_DROP;
        end
        else begin
            r.status = ST_QUERY;
            for (int i = 0; i < tbl_count && !found; i++)
                found = in_entry(i, a);
            r.hit = found;
            if (found && hits_seen != '1)
                hits_seen++;
        end
        r.hit_total = hits_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offers one transaction and blocks until the block takes it. valid stays
    // high on return so back-to-back sends need no extra edge.
    task automatic send_txn(itm_op_t op, logic [63:0] a, logic [63:0] b,
                            bit typed, match_rsp_t want);
        match_rsp_t pred;
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.first_value  <= a;
        req_ch.second_value <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pred = predict_txn(op, a, b);
        pending_rsp.insert(pending_rsp.size(), typed ? want : pred);
    endtask

    task automatic pause_sender(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // sender goes quiet until every owed response has come back
    task automatic wait_for_drain();
        if (pending_rsp.size() != 0) begin
            req_ch.valid <= 1'b0;
            while (pending_rsp.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 7));
    endtask

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ready pattern: random stall bursts, plus one long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left      = 0;
        stall_left     = 0;
        rsp_ch.ready   <= 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                rsp_ch.ready  <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left   = $urandom_range(0, 6);     // start a random stall burst
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // response checker: values sampled at the edge, before any update lands
    always @(posedge clk) begin
        match_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0)
                flag_mismatch("response transaction with nothing outstanding");
            else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    flag_mismatch($sformatf("status got %0d want %s",
                                            rsp_ch.status, want.status.name()));
                if (rsp_ch.hit !== want.hit)
                    flag_mismatch($sformatf("hit got %b want %b",
                                            rsp_ch.hit, want.hit));
                if (rsp_ch.hit_total !== want.hit_total)
                    flag_mismatch($sformatf("hit_total got %0h want %0h",
                                            rsp_ch.hit_total, want.hit_total));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        itm_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
        int          pick;
        int          idx;

        mismatch_count      = 0;
        tbl_count           = 0;
        hits_seen           = '0;
        idle_on             = 1'b1;
        long_hold_req       = 1'b0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_ADD;
        req_ch.first_value  <= '0;
        req_ch.second_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_txn(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b,
                     dir_rows[i].typed, dir_rows[i].want);
            maybe_gap();
        end
        wait_for_drain();

        // Random part. Narrow low intervals fill the table so that drops show
        // up; probes and adds near stored edges drive merges and boundary hits;
        // full-width values exercise every bit of both fields.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 120)
                long_hold_req = 1'b1;
            if (n == 220)
                wait_for_drain();
            if (n == RAND_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;

            op   = ($urandom_range(0, 1) == 0) ? OP_ADD : OP_TEST;
            pick = $urandom_range(0, 9);
            a    = {$urandom, $urandom};
            b    = {$urandom, $urandom};
            if (op == OP_ADD) begin
                if (pick < 4) begin
                    a = 64'($urandom_range(0, 5000));
                    b = a + 64'($urandom_range(0, 30));
                end
                else if (pick < 6 && tbl_count != 0) begin
                    idx = $urandom_range(0, tbl_count - 1);
                    a   = tbl_lo[idx] + 64'($urandom_range(0, 4)) - 64'd2;
                    b   = tbl_hi[idx] + 64'($urandom_range(0, 40)) - 64'd20;
                    if ($urandom_range(0, 1) == 0) begin
                        // end near the low edge, start near the high edge
                        a = b;
                        b = tbl_lo[idx] + 64'($urandom_range(0, 4)) - 64'd2;
                    end
                end
                else if (pick == 8) begin
                    // point or near-edge intervals at the ends of the range
                    if ($urandom_range(0, 1) == 0) begin
                        a = 64'd0;
                        b = 64'($urandom_range(0, 3));
                    end
                    else begin
                        a = VMAX - 64'($urandom_range(0, 3));
                        b = VMAX;
                    end
                end
                else if (pick == 9) begin
                    b = 64'($urandom_range(0, 5000));
                    a = b + 64'($urandom_range(1, 50));
                end
            end
            else begin
                if (pick < 5 && tbl_count != 0) begin
                    idx = $urandom_range(0, tbl_count - 1);
                    case ($urandom_range(0, 3))
                        0:       a = tbl_lo[idx] - 64'd1;
                        1:       a = tbl_lo[idx];
                        2:       a = tbl_hi[idx];
                        default: a = tbl_hi[idx] + 64'd1;
                    endcase
                end
                else if (pick < 8)
                    a = 64'($urandom_range(0, 5100));
                else if (pick == 8)
                    a = ($urandom_range(0, 1) == 0) ? 64'd0 : VMAX;
            end
            send_txn(op, a, b, 1'b0, UNTYPED);
            maybe_gap();
        end

        wait_for_drain();
        // trailing window: anything extra the block emits lands here
        repeat (ENTRIES + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[interval_table_merge_and_match_top] OK");
        else
            $display("[interval_table_merge_and_match_top] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("[interval_table_merge_and_match_top] ERROR");
        $finish;
    end

endmodule
